// ===== hdl/wrgb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrgb_pkg
// Shared widths, codes, item types and gamma table builder for the
// wavelength to RGB colour ramp.
// ----------------------------------------------------------------------------
package wrgb_pkg;

   localparam int COORD_W          = 17;
   localparam int CHAN_W           = 8;
   localparam int MAXI_W           = 8;
   localparam int WAVE_W           = 10;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 10;
   localparam int LANES            = 3;

   localparam int GAMMA_X100       = 80;
   localparam int GAMMA_TABLE_BITS = 10;

   localparam int FRAC_W           = 16;
   localparam int LEN_W            = 30;
   localparam int CN_W             = 23;
   localparam int FN_W             = 26;
   localparam int PROD_W           = CN_W + FN_W;
   localparam int DEN_W            = 16;
   localparam int RCP_W            = 32;
   localparam int RCP_SHIFT        = 31;
   localparam int HALF_SHIFT       = 31;
   localparam int ROM_W            = 17;
   localparam int ROUND_SHIFT      = 16;
   localparam int QUEUE_DEPTH      = 4;

   localparam logic [63:0] RCP_ONE = 64'd1 << RCP_SHIFT;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_INTENSITY = 2'd0,
      CSR_WAVE_START    = 2'd1,
      CSR_WAVE_END      = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      CD_ONE,
      CD_60,
      CD_50,
      CD_20,
      CD_70,
      CD_65
   } chan_den_type;

   typedef enum logic [1:0] {
      FD_ONE,
      FD_400,
      FD_800
   } fac_den_type;

   typedef struct packed {
      logic [LANES-1:0][CN_W-1:0] cn;
      chan_den_type [LANES-1:0]   cd;
      logic [FN_W-1:0]            fn;
      fac_den_type                fd;
   } wrgb_item_type;

   typedef struct packed {
      logic [DEN_W-1:0] den;
      logic [RCP_W-1:0] rcp;
   } den_rcp_type;

   // Wavelength thresholds in Q.16 nanometres
   localparam logic signed [LEN_W-1:0] NM_120 = LEN_W'(120 * 65536);
   localparam logic signed [LEN_W-1:0] NM_240 = LEN_W'(240 * 65536);
   localparam logic signed [LEN_W-1:0] NM_380 = LEN_W'(380 * 65536);
   localparam logic signed [LEN_W-1:0] NM_420 = LEN_W'(420 * 65536);
   localparam logic signed [LEN_W-1:0] NM_440 = LEN_W'(440 * 65536);
   localparam logic signed [LEN_W-1:0] NM_490 = LEN_W'(490 * 65536);
   localparam logic signed [LEN_W-1:0] NM_510 = LEN_W'(510 * 65536);
   localparam logic signed [LEN_W-1:0] NM_580 = LEN_W'(580 * 65536);
   localparam logic signed [LEN_W-1:0] NM_645 = LEN_W'(645 * 65536);
   localparam logic signed [LEN_W-1:0] NM_701 = LEN_W'(701 * 65536);
   localparam logic signed [LEN_W-1:0] NM_780 = LEN_W'(780 * 65536);
   localparam logic signed [LEN_W-1:0] NM_781 = LEN_W'(781 * 65536);

   localparam logic [CN_W-1:0] CN_ONE = CN_W'(65536);
   localparam logic [FN_W-1:0] FN_ONE = FN_W'(65536);

   // Combined divisor and its scaled reciprocal for one channel
   function automatic den_rcp_type den_rcp(input chan_den_type cd, input fac_den_type fd);
      den_rcp_type r;
      case ({cd, fd})
         {CD_ONE, FD_ONE}: r = '{DEN_W'(1),     RCP_W'(RCP_ONE)};
         {CD_ONE, FD_400}: r = '{DEN_W'(400),   RCP_W'(RCP_ONE / 64'd400)};
         {CD_ONE, FD_800}: r = '{DEN_W'(800),   RCP_W'(RCP_ONE / 64'd800)};
         {CD_60,  FD_ONE}: r = '{DEN_W'(60),    RCP_W'(RCP_ONE / 64'd60)};
         {CD_60,  FD_400}: r = '{DEN_W'(24000), RCP_W'(RCP_ONE / 64'd24000)};
         {CD_60,  FD_800}: r = '{DEN_W'(48000), RCP_W'(RCP_ONE / 64'd48000)};
         {CD_50,  FD_ONE}: r = '{DEN_W'(50),    RCP_W'(RCP_ONE / 64'd50)};
         {CD_50,  FD_400}: r = '{DEN_W'(20000), RCP_W'(RCP_ONE / 64'd20000)};
         {CD_50,  FD_800}: r = '{DEN_W'(40000), RCP_W'(RCP_ONE / 64'd40000)};
         {CD_20,  FD_ONE}: r = '{DEN_W'(20),    RCP_W'(RCP_ONE / 64'd20)};
         {CD_20,  FD_400}: r = '{DEN_W'(8000),  RCP_W'(RCP_ONE / 64'd8000)};
         {CD_20,  FD_800}: r = '{DEN_W'(16000), RCP_W'(RCP_ONE / 64'd16000)};
         {CD_70,  FD_ONE}: r = '{DEN_W'(70),    RCP_W'(RCP_ONE / 64'd70)};
         {CD_70,  FD_400}: r = '{DEN_W'(28000), RCP_W'(RCP_ONE / 64'd28000)};
         {CD_70,  FD_800}: r = '{DEN_W'(56000), RCP_W'(RCP_ONE / 64'd56000)};
         {CD_65,  FD_ONE}: r = '{DEN_W'(65),    RCP_W'(RCP_ONE / 64'd65)};
         {CD_65,  FD_400}: r = '{DEN_W'(26000), RCP_W'(RCP_ONE / 64'd26000)};
         {CD_65,  FD_800}: r = '{DEN_W'(52000), RCP_W'(RCP_ONE / 64'd52000)};
         default:          r = '{DEN_W'(1),     RCP_W'(RCP_ONE)};
      endcase
      return r;
   endfunction

   // Integer log2 in Q.32, by repeated squaring
   function automatic logic [63:0] log2_q32(input logic [31:0] v);
      logic [63:0] m;
      logic [63:0] res;
      int          k;
      k = 0;
      for (int s = 1; s < 32; s++) begin
         if ((v >> s) != 32'd0) k = s;
      end
      if (v == 32'd0) return 64'd0;
      m   = 64'(v) << (31 - k);
      res = 64'(k) << 32;
      for (int b = 31; b >= 0; b--) begin
         m = (m * m) >> 31;
         if (m >= 64'h1_0000_0000) begin
            m   = m >> 1;
            res = res + (64'd1 << b);
         end
      end
      return res;
   endfunction

   // One gamma table entry, evaluated at elaboration
   function automatic logic [ROM_W-1:0] gamma_entry(input logic [31:0] i, input int gx100,
                                                    input int bits);
      logic [63:0] a;
      logic [63:0] t;
      logic [63:0] top;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      if (i == 32'd0) return '0;
      a   = (64'(bits) << 32) - log2_q32(i);
      t   = (a * 64'(gx100)) / 64'd100;
      top = 64'd17 << 32;
      if (t > top) return '0;
      top = top - t;
      lo  = 64'd1;
      hi  = 64'd131072;
      for (int n = 0; n < 20; n++) begin
         if (lo < hi) begin
            mid = lo + (hi - lo + 64'd1) / 64'd2;
            if (log2_q32(32'(mid)) <= top) lo = mid;
            else hi = mid - 64'd1;
         end
      end
      return ROM_W'((lo + 64'd1) >> 1);
   endfunction

endpackage
`default_nettype wire

// ===== hdl/wrgb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrgb_if
// Request, response and register write channels of the colour ramp.
// ----------------------------------------------------------------------------
interface wrgb_req_if;
   logic                         valid;
   logic                         ready;
   logic [wrgb_pkg::COORD_W-1:0] norm_coord;
   modport source (output valid, output norm_coord, input ready);
   modport sink   (input valid, input norm_coord, output ready);
endinterface

interface wrgb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [wrgb_pkg::CHAN_W-1:0] red;
   logic [wrgb_pkg::CHAN_W-1:0] green;
   logic [wrgb_pkg::CHAN_W-1:0] blue;
   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface wrgb_csr_if;
   logic                            valid;
   logic                            ready;
   logic [wrgb_pkg::CSR_IDX_W-1:0]  index;
   logic [wrgb_pkg::CSR_DATA_W-1:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ===== hdl/wavelength_to_rgb_gamma_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wavelength_to_rgb_gamma_core
// Normalized spectrum coordinate to gamma corrected 8-bit RGB.
//
// req_ch carries one Q1.16 coordinate per request; rsp_ch returns red, green
// and blue for it, in order, one response per request. csr_ch writes
// max_intensity (0), wavelength_start (1) and wavelength_end (2); other
// indexes are dropped. csr_ch is always ready; write it only while idle.
// Throughput: one request per clock, sustained while rsp_ch is ready.
// Pipeline: a request passes two front stages, the first loaded on the
// accepting edge, one queue slot, and six back stages with the gamma table
// read and the output register.
// Reset clears all valid bits and the queue and loads 255, 380 and 780 into the
// registers. While rsp_ch stalls, the output register and back stages hold;
// the four-entry queue keeps taking requests until full, then req_ch.ready
// drops. Each channel has its own gamma table of 2^GAMMA_TABLE_BITS+1 words.
// ----------------------------------------------------------------------------
module wavelength_to_rgb_gamma_core #(
   parameter int GAMMA_TABLE_BITS = wrgb_pkg::GAMMA_TABLE_BITS
) (
   input  wire logic  clock,
   input  wire logic  reset,
   wrgb_req_if.sink   req_ch,
   wrgb_rsp_if.source rsp_ch,
   wrgb_csr_if.sink   csr_ch
);

   logic [wrgb_pkg::MAXI_W-1:0] max_ff;
   logic [wrgb_pkg::MAXI_W-1:0] max_in;
   logic [wrgb_pkg::WAVE_W-1:0] start_ff;
   logic [wrgb_pkg::WAVE_W-1:0] start_in;
   logic [wrgb_pkg::WAVE_W-1:0] end_ff;
   logic [wrgb_pkg::WAVE_W-1:0] end_in;

   logic                        q_push;
   logic                        q_pop;
   logic                        q_full;
   logic                        q_empty;
   wrgb_pkg::wrgb_item_type     push_item;
   wrgb_pkg::wrgb_item_type     head_item;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      max_in   = max_ff;
      start_in = start_ff;
      end_in   = end_ff;
      if (csr_ch.valid) begin
         case (wrgb_pkg::csr_index_type'(csr_ch.index))
            wrgb_pkg::CSR_MAX_INTENSITY: max_in   = csr_ch.wdata[wrgb_pkg::MAXI_W-1:0];
            wrgb_pkg::CSR_WAVE_START:    start_in = csr_ch.wdata;
            wrgb_pkg::CSR_WAVE_END:      end_in   = csr_ch.wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= wrgb_pkg::MAXI_W'(255);
         start_ff <= wrgb_pkg::WAVE_W'(380);
         end_ff   <= wrgb_pkg::WAVE_W'(780);
      end else begin
         max_ff   <= max_in;
         start_ff <= start_in;
         end_ff   <= end_in;
      end
   end

   wrgb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .wave_start (start_ff),
      .wave_end   (end_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   wrgb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head_item (head_item)
   );

   wrgb_back #(
      .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_item        (head_item),
      .q_pop         (q_pop),
      .max_intensity (max_ff),
      .rsp_ch        (rsp_ch)
   );

endmodule
`default_nettype wire

// ===== hdl/wrgb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrgb_front
// Maps the coordinate onto the wavelength span and classifies it into
// channel ramp terms and an edge factor term.
// ----------------------------------------------------------------------------
module wrgb_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   wrgb_req_if.sink                     req_ch,
   input  wire logic [wrgb_pkg::WAVE_W-1:0] wave_start,
   input  wire logic [wrgb_pkg::WAVE_W-1:0] wave_end,
   input  wire logic                    q_full,
   output logic                         q_push,
   output wrgb_pkg::wrgb_item_type      q_item
);

   localparam int PROD_W = wrgb_pkg::COORD_W + wrgb_pkg::WAVE_W + 2;

   logic                                   adv;
   logic                                   f1_valid_ff;
   logic                                   f2_valid_ff;
   logic signed [wrgb_pkg::LEN_W-1:0]      len_ff;
   logic signed [wrgb_pkg::LEN_W-1:0]      len_in;
   wrgb_pkg::wrgb_item_type                item_ff;
   wrgb_pkg::wrgb_item_type                item_in;
   logic signed [wrgb_pkg::WAVE_W:0]       diff;
   logic signed [wrgb_pkg::COORD_W:0]      xs;
   logic signed [PROD_W-1:0]               prod;
   logic signed [wrgb_pkg::LEN_W-1:0]      dx;

   assign adv          = !(f2_valid_ff && q_full);
   assign req_ch.ready = adv;
   assign q_push       = f2_valid_ff && !q_full;
   assign q_item       = item_ff;

   always_comb begin
      diff   = $signed({1'b0, wave_end}) - $signed({1'b0, wave_start});
      xs     = $signed({1'b0, req_ch.norm_coord});
      prod   = xs * diff;
      len_in = wrgb_pkg::LEN_W'(prod)
             + $signed(wrgb_pkg::LEN_W'({wave_start, {wrgb_pkg::FRAC_W{1'b0}}}));
   end

   always_comb begin
      item_in = '0;
      dx      = '0;
      if (len_ff < wrgb_pkg::NM_380) begin
      end else if (len_ff < wrgb_pkg::NM_440) begin
         item_in.cn[0] = wrgb_pkg::CN_W'(wrgb_pkg::NM_440 - len_ff);
         item_in.cd[0] = wrgb_pkg::CD_60;
         item_in.cn[2] = wrgb_pkg::CN_ONE;
      end else if (len_ff < wrgb_pkg::NM_490) begin
         item_in.cn[1] = wrgb_pkg::CN_W'(len_ff - wrgb_pkg::NM_440);
         item_in.cd[1] = wrgb_pkg::CD_50;
         item_in.cn[2] = wrgb_pkg::CN_ONE;
      end else if (len_ff < wrgb_pkg::NM_510) begin
         item_in.cn[1] = wrgb_pkg::CN_ONE;
         item_in.cn[2] = wrgb_pkg::CN_W'(wrgb_pkg::NM_510 - len_ff);
         item_in.cd[2] = wrgb_pkg::CD_20;
      end else if (len_ff < wrgb_pkg::NM_580) begin
         item_in.cn[0] = wrgb_pkg::CN_W'(len_ff - wrgb_pkg::NM_510);
         item_in.cd[0] = wrgb_pkg::CD_70;
         item_in.cn[1] = wrgb_pkg::CN_ONE;
      end else if (len_ff < wrgb_pkg::NM_645) begin
         item_in.cn[0] = wrgb_pkg::CN_ONE;
         item_in.cn[1] = wrgb_pkg::CN_W'(wrgb_pkg::NM_645 - len_ff);
         item_in.cd[1] = wrgb_pkg::CD_65;
      end else if (len_ff < wrgb_pkg::NM_781) begin
         item_in.cn[0] = wrgb_pkg::CN_ONE;
      end

      if (len_ff < wrgb_pkg::NM_380) begin
      end else if (len_ff < wrgb_pkg::NM_420) begin
         dx         = len_ff - wrgb_pkg::NM_380;
         item_in.fn = wrgb_pkg::FN_W'(wrgb_pkg::NM_120 + (dx <<< 3) - dx);
         item_in.fd = wrgb_pkg::FD_400;
      end else if (len_ff < wrgb_pkg::NM_701) begin
         item_in.fn = wrgb_pkg::FN_ONE;
      end else if (len_ff < wrgb_pkg::NM_781) begin
         dx         = wrgb_pkg::NM_780 - len_ff;
         item_in.fn = wrgb_pkg::FN_W'(wrgb_pkg::NM_240 + (dx <<< 3) - dx);
         item_in.fd = wrgb_pkg::FD_800;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_valid_ff <= req_ch.valid;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         len_ff  <= len_in;
         item_ff <= item_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/wrgb_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrgb_queue
// Small first-in first-out queue between the front and back halves.
// ----------------------------------------------------------------------------
module wrgb_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wrgb_pkg::wrgb_item_type      push_item,
   input  wire logic                    pop,
   output logic                         full,
   output logic                         empty,
   output wrgb_pkg::wrgb_item_type      head_item
);

   localparam int DEPTH = wrgb_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   wrgb_pkg::wrgb_item_type queue_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff;
   logic [PTR_W-1:0]        wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff;
   logic [PTR_W-1:0]        rd_ptr_in;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic                    do_push;
   logic                    do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = queue_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) queue_ff[wr_ptr_ff] <= push_item;
   end

endmodule
`default_nettype wire

// ===== hdl/wrgb_gamma_rom.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrgb_gamma_rom
// Gamma curve table, Q1.16 entries, registered read.
// ----------------------------------------------------------------------------
module wrgb_gamma_rom #(
   parameter int TABLE_BITS = wrgb_pkg::GAMMA_TABLE_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic [TABLE_BITS:0]          addr,
   output logic [wrgb_pkg::ROM_W-1:0]        data
);

   localparam int DEPTH = (1 << TABLE_BITS) + 1;

   logic [wrgb_pkg::ROM_W-1:0] rom_tab [DEPTH];
   logic [wrgb_pkg::ROM_W-1:0] data_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      localparam logic [wrgb_pkg::ROM_W-1:0] VALUE =
         wrgb_pkg::gamma_entry(32'(i), wrgb_pkg::GAMMA_X100, TABLE_BITS);
      assign rom_tab[i] = VALUE;
   end

   always_ff @(posedge clock) begin
      if (en) data_ff <= rom_tab[addr];
   end

   assign data = data_ff;

endmodule
`default_nettype wire

// ===== hdl/wrgb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrgb_back
// Per channel: product of ramp and factor, rounded table index by
// reciprocal division, gamma lookup and intensity scaling.
// ----------------------------------------------------------------------------
module wrgb_back #(
   parameter int GAMMA_TABLE_BITS = wrgb_pkg::GAMMA_TABLE_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         q_empty,
   input  wrgb_pkg::wrgb_item_type           q_item,
   output logic                              q_pop,
   input  wire logic [wrgb_pkg::MAXI_W-1:0]  max_intensity,
   wrgb_rsp_if.source                        rsp_ch
);

   localparam int LANES  = wrgb_pkg::LANES;
   localparam int STAGES = 6;
   localparam int IDX_W  = GAMMA_TABLE_BITS + 1;
   localparam int T_W    = GAMMA_TABLE_BITS + 17;
   localparam int NUM_W  = GAMMA_TABLE_BITS + 49;
   localparam int SUM_W  = wrgb_pkg::MAXI_W + wrgb_pkg::ROM_W;
   localparam logic [T_W-1:0]   ROM_TOP = T_W'(1) << GAMMA_TABLE_BITS;
   localparam logic [SUM_W-1:0] HALF    = SUM_W'(1) << (wrgb_pkg::ROUND_SHIFT - 1);

   logic                              adv;
   logic [STAGES-1:0]                 stage_valid_ff;
   wrgb_pkg::den_rcp_type             dr [LANES];

   logic [wrgb_pkg::PROD_W-1:0]       prod_ff  [LANES];
   logic [wrgb_pkg::DEN_W-1:0]        den1_ff  [LANES];
   logic [wrgb_pkg::RCP_W-1:0]        rcp1_ff  [LANES];
   logic [NUM_W-1:0]                  num      [LANES];
   logic [T_W-1:0]                    t_ff     [LANES];
   logic [wrgb_pkg::DEN_W-1:0]        den2_ff  [LANES];
   logic [wrgb_pkg::RCP_W-1:0]        rcp2_ff  [LANES];
   logic [T_W+wrgb_pkg::RCP_W-1:0]    qprod    [LANES];
   logic [T_W-1:0]                    qe_ff    [LANES];
   logic [T_W-1:0]                    t3_ff    [LANES];
   logic [wrgb_pkg::DEN_W-1:0]        den3_ff  [LANES];
   logic [T_W+wrgb_pkg::DEN_W-1:0]    qd       [LANES];
   logic [T_W-1:0]                    rem      [LANES];
   logic [T_W-1:0]                    quo      [LANES];
   logic [IDX_W-1:0]                  idx_in   [LANES];
   logic [IDX_W-1:0]                  idx_ff   [LANES];
   logic [wrgb_pkg::ROM_W-1:0]        rom_data [LANES];
   logic [SUM_W-1:0]                  scaled   [LANES];
   logic [wrgb_pkg::CHAN_W-1:0]       out_ff   [LANES];

   assign adv   = !stage_valid_ff[STAGES-1] || rsp_ch.ready;
   assign q_pop = adv && !q_empty;

   assign rsp_ch.valid = stage_valid_ff[STAGES-1];
   assign rsp_ch.red   = out_ff[0];
   assign rsp_ch.green = out_ff[1];
   assign rsp_ch.blue  = out_ff[2];

   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         dr[j]    = wrgb_pkg::den_rcp(q_item.cd[j], q_item.fd);
         num[j]   = NUM_W'({prod_ff[j], {GAMMA_TABLE_BITS{1'b0}}})
                  + (NUM_W'(den1_ff[j]) << wrgb_pkg::HALF_SHIFT);
         qprod[j] = T_W'(t_ff[j]) * rcp2_ff[j];
         qd[j]    = qe_ff[j] * den3_ff[j];
         rem[j]   = t3_ff[j] - T_W'(qd[j]);
         quo[j]   = qe_ff[j] + T_W'(rem[j] >= T_W'(den3_ff[j]));
         idx_in[j] = (quo[j] > ROM_TOP) ? IDX_W'(ROM_TOP) : IDX_W'(quo[j]);
         scaled[j] = (SUM_W'(max_intensity) * SUM_W'(rom_data[j])) + HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else if (adv) begin
         stage_valid_ff <= {stage_valid_ff[STAGES-2:0], !q_empty};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < LANES; j++) begin
            prod_ff[j] <= q_item.cn[j] * q_item.fn;
            den1_ff[j] <= dr[j].den;
            rcp1_ff[j] <= dr[j].rcp;
            t_ff[j]    <= num[j][32 +: T_W];
            den2_ff[j] <= den1_ff[j];
            rcp2_ff[j] <= rcp1_ff[j];
            qe_ff[j]   <= qprod[j][wrgb_pkg::RCP_SHIFT +: T_W];
            t3_ff[j]   <= t_ff[j];
            den3_ff[j] <= den2_ff[j];
            idx_ff[j]  <= idx_in[j];
            out_ff[j]  <= scaled[j][wrgb_pkg::ROUND_SHIFT +: wrgb_pkg::CHAN_W];
         end
      end
   end

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      wrgb_gamma_rom #(
         .TABLE_BITS (GAMMA_TABLE_BITS)
      ) u_rom (
         .clock (clock),
         .en    (adv),
         .addr  (idx_ff[j]),
         .data  (rom_data[j])
      );
   end

endmodule
`default_nettype wire

// ===== hdl/wrgb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrgb_checker
// Port-level checks of the colour ramp core, bound to the top level.
// ----------------------------------------------------------------------------
module wrgb_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [wrgb_pkg::CHAN_W-1:0] red,
   input wire logic [wrgb_pkg::CHAN_W-1:0] green,
   input wire logic [wrgb_pkg::CHAN_W-1:0] blue
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(red) && $stable(green) && $stable(blue))
      else $error("response payload changed while stalled");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_req_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request channel not open after reset");

endmodule

bind wavelength_to_rgb_gamma_core wrgb_checker u_wrgb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .red       (rsp_ch.red),
   .green     (rsp_ch.green),
   .blue      (rsp_ch.blue)
);
`default_nettype wire
